// ----- design/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W      = 5;
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } spq_action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } spq_entry_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic       push_en;
        logic       pop_en;
        spq_entry_t new_entry;
    } spq_ctrl_t;

endpackage
`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: handshake, fill count, cell row.
// A bounded priority queue of QUEUE_DEPTH entries kept sorted highest
// priority first in a row of identical cells, cell 0 being the head. Each
// request is a push (s_action = 0) or a pop (s_action = 1) and yields
// exactly one result. A push is placed ahead of every stored entry of equal
// or lower priority, except that it never displaces the head on a tie: an entry
// equal to the head goes directly behind it. A push on a full queue is
// refused with status 2, a pop on an empty queue returns 0 with status 1.
// Every result carries the fill count after the request and an empty flag.
// Throughput is one request per clock while the consumer keeps up: the new
// priority is broadcast to all cells, each compares it with its own entry in
// the same cycle, and every cell then loads from its left neighbor, its right
// neighbor, the new entry or itself. m_valid rises in the cycle after
// acceptance. The result register frees up in the cycle it is taken, so
// s_ready stays high while the consumer keeps up. No clearing pass is needed
// after reset: the fill count alone tells which cells hold entries.
`default_nettype none
module sorted_priority_queue (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_action,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] s_entry_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]  s_entry_priority,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [spq_pkg::VALUE_W-1:0]     m_popped_value,
    output logic [1:0]                             m_status,
    output logic [spq_pkg::FILL_W-1:0]             m_fill_count,
    output logic                                   m_now_empty
);
    import spq_pkg::*;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] popped_reg;
    logic signed [VALUE_W-1:0] popped_next;
    spq_status_t               status_reg;
    spq_status_t               status_next;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    spq_ctrl_t                 ctrl;

    logic       [QUEUE_DEPTH-1:0] occ;
    logic       [QUEUE_DEPTH-1:0] flag;
    spq_entry_t [QUEUE_DEPTH-1:0] entry;

    // Accept a new request whenever the result register is empty or drains
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Broadcast to the cell row; refused requests leave the store alone
    always_comb begin
        ctrl.push_en         = accept && (s_action == ACT_PUSH) && !is_full;
        ctrl.pop_en          = accept && (s_action == ACT_POP) && !is_empty;
        ctrl.new_entry.value = s_entry_value;
        ctrl.new_entry.prio  = s_entry_priority;
    end

    // Cell row: entries move right on a push, left on a pop
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        spq_entry_t right_in;
        logic       left_flag_in;
        spq_entry_t left_in;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_head
            assign left_flag_in = 1'b0;
            assign left_in      = '0;
        end else begin : g_body
            assign left_flag_in = flag[i-1];
            assign left_in      = entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_in = '0;
        end else begin : g_mid
            assign right_in = entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .is_head     (i == 0),
            .occupied    (occ[i]),
            .left_flag   (left_flag_in),
            .left_entry  (left_in),
            .right_entry (right_in),
            .flag        (flag[i]),
            .entry       (entry[i])
        );
    end

    // Count update and result payload
    always_comb begin
        count_next  = count_reg;
        popped_next = '0;
        status_next = STATUS_OK;
        unique case (s_action)
            ACT_PUSH: begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP: begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    count_next  = count_reg - 1'b1;
                    popped_next = entry[0].value;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = popped_reg;
    assign m_status       = status_reg;
    assign m_fill_count   = FILL_W'(count_reg);
    assign m_now_empty    = is_empty;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted push did not grow the count");

    a_pop_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ACT_POP && is_empty) |=>
            (m_valid && m_status == STATUS_EMPTY && m_popped_value == '0))
        else $error("empty pop result wrong");

    a_no_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("count moved without a request");
`endif

endmodule
`default_nettype wire

// ----- design/spq_cell.sv -----
// One slot of the sorted store: compare, hold, take from a neighbor.
`default_nettype none
module spq_cell (
    input  wire logic                aclk,
    input  wire spq_pkg::spq_ctrl_t  ctrl,
    input  wire logic                is_head,
    input  wire logic                occupied,
    input  wire logic                left_flag,
    input  wire spq_pkg::spq_entry_t left_entry,
    input  wire spq_pkg::spq_entry_t right_entry,
    output logic                     flag,
    output spq_pkg::spq_entry_t      entry
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Insert point is here or further left: the head yields only to a
    // strictly higher priority, other slots yield on equal or higher.
    always_comb begin
        if (!occupied) begin
            flag = 1'b1;
        end else if (is_head) begin
            flag = (ctrl.new_entry.prio > entry_reg.prio);
        end else begin
            flag = (ctrl.new_entry.prio >= entry_reg.prio);
        end
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.pop_en) begin
            entry_next = right_entry;
        end else if (ctrl.push_en) begin
            if (left_flag) begin
                entry_next = left_entry;
            end else if (flag) begin
                entry_next = ctrl.new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the sorted priority queue: random push/pop traffic with stalls.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int TOTAL_REQUESTS = 750;
    localparam int MAX_WAIT       = 12;
    localparam int SETTLE_CYCLES  = 10;
    // The limit allows several times the worst case per request (sender gap,
    // receiver stall, result latency).
    localparam int CYCLE_LIMIT    = 200000;

    // One request as the sender presents it. hold_for_drain makes the sender
    // wait until every awaited result has come back before presenting it.
    typedef struct {
        spq_action_t               action;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        bit                        hold_for_drain;
    } spq_request_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        spq_status_t               status;
        logic [FILL_W-1:0]         fill;
        logic                      empty;
    } spq_result_t;

    logic                      aclk             = 1'b0;
    logic                      aresetn          = 1'b0;
    logic                      s_valid          = 1'b0;
    logic                      s_ready;
    logic                      s_action         = 1'b0;
    logic signed [VALUE_W-1:0] s_entry_value    = '0;
    logic signed [PRIO_W-1:0]  s_entry_priority = '0;
    logic                      m_valid;
    logic                      m_ready          = 1'b0;
    logic signed [VALUE_W-1:0] m_popped_value;
    logic [1:0]                m_status;
    logic [FILL_W-1:0]         m_fill_count;
    logic                      m_now_empty;

    spq_request_t pending_requests[$];
    spq_result_t  awaited_results[$];

    // Shadow copy of the sorted store, slot 0 is the head
    logic signed [VALUE_W-1:0] held_value[QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  held_prio[QUEUE_DEPTH];
    int                        held_count = 0;

    int  failures       = 0;
    int  accepted_count = 0;
    int  cycle_count    = 0;
    bit  request_taken  = 1'b0;
    bit  result_taken   = 1'b0;
    int  send_gap       = 0;
    int  recv_stall     = 0;
    bit  send_steady    = 1'b0;
    bit  recv_steady    = 1'b0;

    sorted_priority_queue DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_entry_value    (s_entry_value),
        .s_entry_priority (s_entry_priority),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_popped_value   (m_popped_value),
        .m_status         (m_status),
        .m_fill_count     (m_fill_count),
        .m_now_empty      (m_now_empty)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one accepted request to the shadow store and return the result
    // the block must give for it.
    task automatic serve_request(input logic act, input logic signed [VALUE_W-1:0] value,
                                 input logic signed [PRIO_W-1:0] prio,
                                 output spq_result_t res);
        int slot;
        int i;
        res.value  = '0;
        res.status = STATUS_OK;
        if (spq_action_t'(act) == ACT_PUSH) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                // Land ahead of equal or lower priorities, but never ahead of the head
                slot = 0;
                if (held_count != 0 && prio <= held_prio[0]) begin
                    slot = 1;
                    while (slot < held_count && held_prio[slot] > prio)
                        slot++;
                end
                for (i = held_count; i > slot; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[slot] = value;
                held_prio[slot]  = prio;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.value = held_value[0];
                for (i = 1; i < held_count; i++) begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1]  = held_prio[i];
                end
                held_count--;
            end
        end
        res.fill  = held_count[FILL_W-1:0];
        res.empty = (held_count == 0);
    endtask

    function automatic void add_request(spq_action_t act, logic signed [VALUE_W-1:0] value,
                                        logic signed [PRIO_W-1:0] prio, bit hold);
        spq_request_t req;
        req.action         = act;
        req.value          = value;
        req.prio           = prio;
        req.hold_for_drain = hold;
        pending_requests.push_back(req);
    endfunction

    // Favor the extremes and zero, otherwise any word
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mix in a narrow band around zero so that ties with the head and with
    // stored entries come up often.
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 9))
            0:             return 16'sh7fff;
            1:             return 16'sh8000;
            2, 3, 4, 5:    return PRIO_W'(int'($urandom_range(0, 4)) - 2);
            default:       return PRIO_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Draw the wait before the next request or result; now and then switch
    // between idling and running flat out.
    function automatic int next_wait(inout bit steady);
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Sender: present a request at the falling edge, hold it until taken
    always @(negedge aclk) begin
        spq_request_t req;
        if (aresetn && (!s_valid || request_taken)) begin
            if (request_taken)
                send_gap = next_wait(send_steady);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].hold_for_drain && awaited_results.size() != 0)) begin
                req = pending_requests.pop_front();
                s_valid          <= 1'b1;
                s_action         <= req.action;
                s_entry_value    <= req.value;
                s_entry_priority <= req.prio;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall for a random wait after each result
    always @(negedge aclk) begin
        if (aresetn) begin
            if (result_taken)
                recv_stall = next_wait(recv_steady);
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: check each result against the oldest awaited one, then
    // predict the result of any request taken at this edge.
    always @(posedge aclk) begin
        spq_result_t want;
        spq_result_t got;
        if (aresetn) begin
            request_taken <= s_valid && s_ready;
            result_taken  <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with none awaited: popped_value %0d status %0d",
                           m_popped_value, m_status);
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_popped_value !== want.value) begin
                        $error("popped_value: expected %0d, got %0d", want.value, m_popped_value);
                        failures++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        failures++;
                    end
                    if (m_fill_count !== want.fill) begin
                        $error("fill_count: expected %0d, got %0d", want.fill, m_fill_count);
                        failures++;
                    end
                    if (m_now_empty !== want.empty) begin
                        $error("now_empty: expected %0d, got %0d", want.empty, m_now_empty);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                serve_request(s_action, s_entry_value, s_entry_priority, got);
                awaited_results.push_back(got);
                accepted_count++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int push_weight;
        int phase;
        int i;

        // Directed opening: empty pop, priority extremes, displacing the head,
        // a tie with the head, a tie at the tail, then fill up and overflow.
        add_request(ACT_POP, 32'sd5, 16'sd5, 1'b0);
        add_request(ACT_PUSH, 32'sh8000_0000, 16'sh8000, 1'b0);
        add_request(ACT_PUSH, 32'sh7fff_ffff, 16'sh7fff, 1'b0);
        add_request(ACT_PUSH, 32'sd1, 16'sh7fff, 1'b0);
        add_request(ACT_PUSH, 32'sd2, 16'sh8000, 1'b0);
        add_request(ACT_PUSH, 32'sd0, 16'sd0, 1'b0);
        add_request(ACT_PUSH, -32'sd1, -16'sd1, 1'b0);
        add_request(ACT_POP, '0, '0, 1'b0);
        for (i = 0; i < 11; i++)
            add_request(ACT_PUSH, 32'sd100 + i, PRIO_W'(i * 3000 - 15000), 1'b0);
        add_request(ACT_PUSH, 32'sd3, 16'sd5, 1'b0);
        add_request(ACT_POP, $urandom, PRIO_W'($urandom_range(0, 65535)), 1'b0);
        add_request(ACT_POP, $urandom, PRIO_W'($urandom_range(0, 65535)), 1'b0);

        // Random phases, each leaning toward pushes or pops so the store
        // swings between empty and full. Every fourth phase ends with a request
        // that waits for a drained pipeline.
        phase = 0;
        while (pending_requests.size() < TOTAL_REQUESTS) begin
            case ($urandom_range(0, 3))
                0:       push_weight = 25;
                1:       push_weight = 50;
                2:       push_weight = 75;
                default: push_weight = 90;
            endcase
            repeat ($urandom_range(10, 60))
                add_request(($urandom_range(0, 99) < push_weight) ? ACT_PUSH : ACT_POP,
                            pick_value(), pick_prio(), 1'b0);
            if (phase % 4 == 0)
                pending_requests[pending_requests.size() - 1].hold_for_drain = 1'b1;
            phase++;
        end

        // Hold reset, then release it at a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        i = pending_requests.size();
        do @(negedge aclk);
        while (accepted_count != i || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
